@@ hw/rtl/phsm_pkg.sv @@
// Package for the pulse sequence header matcher.
// Holds the item structs, opcodes, register indexes and sizes shared by all files.
// No dependencies.
package phsm_pkg;

    // Sizes of the pattern tables and fields.
    localparam int MAX_STEPS     = 16;
    localparam int DURATION_BITS = 24;
    localparam int STEP_BITS     = 4;
    localparam int LEN_BITS      = 5;
    localparam int TOL_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int PROD_BITS     = DURATION_BITS + TOL_BITS;

    // Reset values of the configuration registers.
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(51);
    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1);

    // Item opcodes; the unused code is ignored.
    typedef enum logic [1:0] {
        OP_TRANSITION = 2'd0,
        OP_WR_NORMAL  = 2'd1,
        OP_WR_REPEAT  = 2'd2
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TOLERANCE  = 2'd0,
        CFG_NORMAL_LEN = 2'd1,
        CFG_REPEAT_LEN = 2'd2
    } t_cfg_index;

    // Frame type codes of a result item.
    localparam logic FRAME_NORMAL = 1'b0;
    localparam logic FRAME_REPEAT = 1'b1;

    // Input item.
    typedef struct packed {
        t_opcode                  opcode;
        logic [DURATION_BITS-1:0] duration_us;
        logic                     line_level;
        logic [STEP_BITS-1:0]     step_index;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic                     frame_type;
        logic [DURATION_BITS-1:0] excess_us;
        logic                     final_level;
    } t_out_item;

    // Command from the top level to one matcher.
    typedef struct packed {
        logic                     step_en;
        logic                     wr_en;
        logic [STEP_BITS-1:0]     wr_index;
        logic [DURATION_BITS-1:0] duration;
        logic                     level;
    } t_match_cmd;

    // Status from one matcher back to the top level.
    typedef struct packed {
        logic                     hit;
        logic [DURATION_BITS-1:0] excess;
    } t_match_res;

endpackage

@@ hw/rtl/phsm_matcher.sv @@
// One header pattern matcher: step table, duration compare and progress counter.
// Depends on phsm_pkg.
module phsm_matcher
    import phsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_match_cmd          i_cmd,
    input  logic [TOL_BITS-1:0] i_tolerance,
    input  logic [LEN_BITS-1:0] i_length,
    input  logic                i_flush,
    output t_match_res          o_res
);

    // Pattern table, undefined until written.
    logic [DURATION_BITS-1:0] r_dur [MAX_STEPS];
    logic                     r_lvl [MAX_STEPS];
    logic [STEP_BITS-1:0]     r_progress;
    logic [STEP_BITS-1:0]     n_progress;

    logic [LEN_BITS-1:0]      len_eff;
    logic [STEP_BITS-1:0]     cur_step;
    logic [DURATION_BITS-1:0] exp_dur;
    logic                     exp_lvl;
    logic [DURATION_BITS-1:0] diff;
    logic [PROD_BITS-1:0]     tol_prod;
    logic                     in_tol;
    logic                     at_least;
    logic                     last;
    logic                     step_ok;

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_dur[i_cmd.wr_index] <= i_cmd.duration;
            r_lvl[i_cmd.wr_index] <= i_cmd.level;
        end
    end

    // A length of zero acts as one, and a length past the table as the table size.
    always_comb begin
        if (i_length == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (i_length > LEN_BITS'(MAX_STEPS)) begin
            len_eff = LEN_BITS'(MAX_STEPS);
        end else begin
            len_eff = i_length;
        end
    end

    // Progress left at or past the length (after a length write) restarts at step zero.
    assign cur_step = ({1'b0, r_progress} >= len_eff) ? '0 : r_progress;
    assign exp_dur  = r_dur[cur_step];
    assign exp_lvl  = r_lvl[cur_step];
    assign last     = (({1'b0, cur_step} + LEN_BITS'(1)) == len_eff);

    // Relative tolerance check: |a - e| * 256 < tol * e.
    assign diff     = (i_cmd.duration >= exp_dur) ? (i_cmd.duration - exp_dur)
                                                  : (exp_dur - i_cmd.duration);
    assign tol_prod = {{DURATION_BITS{1'b0}}, i_tolerance} * {{TOL_BITS{1'b0}}, exp_dur};
    assign in_tol   = ({diff, 8'b0} < tol_prod);

    // The last step also takes any longer duration: a * 256 + tol * e > e * 256.
    assign at_least = (({1'b0, i_cmd.duration, 8'b0} + {1'b0, tol_prod})
                       > {1'b0, exp_dur, 8'b0});

    assign step_ok  = (i_cmd.level == exp_lvl) && (in_tol || (last && at_least));

    // Completion and excess duration of the last step.
    always_comb begin
        o_res.hit = i_cmd.step_en && step_ok && last;
        if (in_tol || (i_cmd.duration <= exp_dur)) begin
            o_res.excess = '0;
        end else begin
            o_res.excess = i_cmd.duration - exp_dur;
        end
    end

    // Progress update: a mismatch, a completion or a match elsewhere restarts it.
    always_comb begin
        n_progress = r_progress;
        if (i_cmd.step_en) begin
            if (i_flush || !step_ok || last) begin
                n_progress = '0;
            end else begin
                n_progress = cur_step + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_progress <= '0;
        end else begin
            r_progress <= n_progress;
        end
    end

endmodule

@@ hw/rtl/pulse_sequence_header_matcher.sv @@
// Top level of the pulse sequence header matcher.
// Input register, two pattern matchers, result register and configuration registers.
// Depends on phsm_pkg and phsm_matcher.
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_ready        i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready      o_out_item (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// An accepted item is held in the input register; its result, if any, is loaded
// into the result register as the item leaves the input register.
// One item per cycle is sustained while the result is not stalled: each matcher
// does a table read, one 8x24 multiply and compares between the input register
// and the result register. Reset clears the progress counters and valid flags,
// sets the configuration registers to reset values; the pattern tables keep theirs.
// A stalled result holds the input register; input stays open while it drains.
module pulse_sequence_header_matcher
    import phsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [TOL_BITS-1:0]     i_cfg_data
);

    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [TOL_BITS-1:0] r_tolerance;
    logic [LEN_BITS-1:0] r_normal_len;
    logic [LEN_BITS-1:0] r_repeat_len;

    logic                advance;
    logic                in_accept;
    t_match_cmd          normal_cmd;
    t_match_cmd          repeat_cmd;
    t_match_res          normal_res;
    t_match_res          repeat_res;
    logic                any_hit;

    // The held item moves on whenever the result register is free or draining.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= TOL_RESET;
            r_normal_len <= LEN_RESET;
            r_repeat_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                CFG_NORMAL_LEN: r_normal_len <= i_cfg_data[LEN_BITS-1:0];
                CFG_REPEAT_LEN: r_repeat_len <= i_cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Commands to the two matchers.
    always_comb begin
        normal_cmd.step_en  = advance && (r_in_item.opcode == OP_TRANSITION);
        normal_cmd.wr_en    = advance && (r_in_item.opcode == OP_WR_NORMAL);
        normal_cmd.wr_index = r_in_item.step_index;
        normal_cmd.duration = r_in_item.duration_us;
        normal_cmd.level    = r_in_item.line_level;
        repeat_cmd          = normal_cmd;
        repeat_cmd.wr_en    = advance && (r_in_item.opcode == OP_WR_REPEAT);
    end

    // A completion of either matcher restarts the other one as well.
    phsm_matcher u_normal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (normal_cmd),
        .i_tolerance (r_tolerance),
        .i_length    (r_normal_len),
        .i_flush     (repeat_res.hit),
        .o_res       (normal_res)
    );

    phsm_matcher u_repeat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (repeat_cmd),
        .i_tolerance (r_tolerance),
        .i_length    (r_repeat_len),
        .i_flush     (normal_res.hit),
        .o_res       (repeat_res)
    );

    assign any_hit = normal_res.hit || repeat_res.hit;

    // Result register; the normal header wins when both complete.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (any_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (any_hit) begin
            r_out_item.frame_type  <= normal_res.hit ? FRAME_NORMAL : FRAME_REPEAT;
            r_out_item.excess_us   <= normal_res.hit ? normal_res.excess
                                                     : repeat_res.excess;
            r_out_item.final_level <= r_in_item.line_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hw/rtl/phsm_checker.sv @@
// Port-level checks for the pulse sequence header matcher, bound to the top level.
// Depends on phsm_pkg and pulse_sequence_header_matcher.
module phsm_checker
    import phsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_ready,
    input  t_in_item                i_in_item,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  t_out_item               o_out_item,
    input  logic                    i_cfg_valid,
    input  logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [TOL_BITS-1:0]     i_cfg_data
);

    // A result item waiting for the sink holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed or dropped while stalled");

    // With the result register empty, the input side never blocks.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked although no result is pending");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind pulse_sequence_header_matcher phsm_checker u_phsm_checker (.*);

@@ bench/phsm_header_checker.sv @@
`timescale 1ns / 100ps
// Checker for the pulse sequence header matcher: watches the item, result and register channels.
// Predicts every header match on its own copy of the pattern tables and compares each result item.
// Depends on phsm_pkg.
module phsm_header_checker
    import phsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_in_item                i_in_item,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_out_item               i_out_item,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [TOL_BITS-1:0]     i_cfg_data,
    output int                      o_fail_count,
    output int                      o_outstanding,
    output int                      o_normal_hits,
    output int                      o_repeat_hits
);

    localparam int M_NORMAL = 0;
    localparam int M_REPEAT = 1;

    // Shadow copy of the pattern tables, progress counters and registers.
    logic [DURATION_BITS-1:0] step_dur   [2][MAX_STEPS];
    logic                     step_lvl   [2][MAX_STEPS];
    logic [LEN_BITS-1:0]      progress   [2];
    logic [LEN_BITS-1:0]      length_reg [2];
    logic [TOL_BITS-1:0]      tolerance;

    // Header matches predicted but not yet seen on the result channel.
    t_out_item expected_headers [$];
    int        errors      = 0;
    int        normal_hits = 0;
    int        repeat_hits = 0;

    // A length of zero behaves as one step, anything above the table size as a full table.
    function automatic int unsigned steps_in_use(input logic [LEN_BITS-1:0] r);
        if (r == '0) return 1;
        if (r > MAX_STEPS) return MAX_STEPS;
        return r;
    endfunction

    // Advances one matcher by a transition; returns 1 when its pattern completes.
    function automatic logic step_pattern(input int m, input logic [DURATION_BITS-1:0] a,
                                          input logic lvl,
                                          output logic [DURATION_BITS-1:0] excess);
        longint unsigned act;
        longint unsigned exp_d;
        longint unsigned diff;
        longint unsigned tol;
        int unsigned     len;
        int unsigned     p;
        logic            close;
        logic            last;
        len = steps_in_use(length_reg[m]);
        p   = progress[m];
        // A matcher left beyond a shortened pattern starts over before comparing.
        if (p >= len) p = 0;
        act    = a;
        exp_d  = step_dur[m][p];
        tol    = tolerance;
        diff   = (act >= exp_d) ? act - exp_d : exp_d - act;
        close  = (diff * 256 < tol * exp_d);
        last   = (p + 1 == len);
        excess = '0;
        if (lvl == step_lvl[m][p] &&
            (close || (last && act * 256 + tol * exp_d > exp_d * 256))) begin
            p++;
            if (p == len) begin
                progress[m] = '0;
                if (!close && act > exp_d) excess = DURATION_BITS'(act - exp_d);
                return 1'b1;
            end
            progress[m] = LEN_BITS'(p);
        end else begin
            // A mismatch restarts the matcher; the transition is not retried as a first step.
            progress[m] = '0;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_out_item                want;
        logic [DURATION_BITS-1:0] excess;
        logic                     hit;
        int                       m;
        if (!i_rst_n) begin
            progress[M_NORMAL]   = '0;
            progress[M_REPEAT]   = '0;
            length_reg[M_NORMAL] = LEN_RESET;
            length_reg[M_REPEAT] = LEN_RESET;
            tolerance            = TOL_RESET;
            expected_headers.delete();
        end else begin
            // Compare each delivered result item with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_headers.size() == 0) begin
                    $display("%0t: result item with no match pending: frame_type %0d excess_us %0d final_level %0d",
                             $time, i_out_item.frame_type, i_out_item.excess_us,
                             i_out_item.final_level);
                    errors++;
                end else begin
                    want = expected_headers.pop_front();
                    if (i_out_item.frame_type !== want.frame_type) begin
                        $display("%0t: frame_type expected %0d, got %0d",
                                 $time, want.frame_type, i_out_item.frame_type);
                        errors++;
                    end
                    if (i_out_item.excess_us !== want.excess_us) begin
                        $display("%0t: excess_us expected %0d, got %0d",
                                 $time, want.excess_us, i_out_item.excess_us);
                        errors++;
                    end
                    if (i_out_item.final_level !== want.final_level) begin
                        $display("%0t: final_level expected %0d, got %0d",
                                 $time, want.final_level, i_out_item.final_level);
                        errors++;
                    end
                end
            end

            // Predict the effect of each accepted input item.
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.opcode)
                    OP_WR_NORMAL, OP_WR_REPEAT: begin
                        m = (i_in_item.opcode == OP_WR_REPEAT) ? M_REPEAT : M_NORMAL;
                        step_dur[m][i_in_item.step_index] = i_in_item.duration_us;
                        step_lvl[m][i_in_item.step_index] = i_in_item.line_level;
                    end
                    OP_TRANSITION: begin
                        hit = 1'b0;
                        // The normal matcher has priority; the repeat one is skipped on its hit.
                        if (step_pattern(M_NORMAL, i_in_item.duration_us,
                                         i_in_item.line_level, excess)) begin
                            want.frame_type = FRAME_NORMAL;
                            hit = 1'b1;
                            normal_hits++;
                        end else if (step_pattern(M_REPEAT, i_in_item.duration_us,
                                                  i_in_item.line_level, excess)) begin
                            want.frame_type = FRAME_REPEAT;
                            hit = 1'b1;
                            repeat_hits++;
                        end
                        if (hit) begin
                            want.excess_us   = excess;
                            want.final_level = i_in_item.line_level;
                            progress[M_NORMAL] = '0;
                            progress[M_REPEAT] = '0;
                            expected_headers.push_back(want);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Register writes; an unknown index is dropped.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_TOLERANCE:  tolerance            = i_cfg_data;
                    CFG_NORMAL_LEN: length_reg[M_NORMAL] = i_cfg_data[LEN_BITS-1:0];
                    CFG_REPEAT_LEN: length_reg[M_REPEAT] = i_cfg_data[LEN_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count  <= errors;
        o_outstanding <= expected_headers.size();
        o_normal_hits <= normal_hits;
        o_repeat_hits <= repeat_hits;
    end

endmodule

@@ bench/tb_pulse_sequence_header_matcher.sv @@
`timescale 1ns / 100ps
// Testbench top for the pulse sequence header matcher: drives items and register writes.
// Depends on phsm_pkg, pulse_sequence_header_matcher and phsm_header_checker.
module tb_pulse_sequence_header_matcher;
    import phsm_pkg::*;

    localparam t_opcode    OP_UNUSED   = t_opcode'(2'd3);
    localparam t_cfg_index CFG_UNUSED  = t_cfg_index'(2'd3);
    localparam int         LATENCY     = 2;
    localparam int         ITEM_TARGET = 1250;
    localparam int         M_NORMAL    = 0;
    localparam int         M_REPEAT    = 1;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BURSTY} t_sink_mode;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in_item                in_item   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out_item               out_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [TOL_BITS-1:0]     cfg_data  = '0;
    int                      fail_count;
    int                      outstanding;
    int                      normal_hits;
    int                      repeat_hits;

    // Stimulus side view of the tables and registers, used to shape well-formed frames.
    logic [DURATION_BITS-1:0] pat_e [2][MAX_STEPS];
    logic                     pat_l [2][MAX_STEPS];
    logic [TOL_BITS-1:0]      tol_now = TOL_RESET;
    int                       len_now [2] = '{1, 1};
    int                       burst_left  = 0;
    int                       items_sent  = 0;
    int                       phases      = 0;

    t_sink_mode sink_mode   = SINK_OPEN;
    int         cycle_count = 0;
    int         hold_left   = 0;

    pulse_sequence_header_matcher uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    phsm_header_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_normal_hits (normal_hits),
        .o_repeat_hits (repeat_hits)
    );

    always #10 clk = ~clk;

    // Result receiver: the stall pattern is picked again at random at regular points in the run.
    always @(posedge clk) begin
        if (cycle_count % 256 == 0) sink_mode = t_sink_mode'($urandom_range(0, 3));
        cycle_count++;
        case (sink_mode)
            SINK_OPEN:     out_ready <= 1'b1;
            SINK_RANDOM:   out_ready <= ($urandom_range(0, 1) == 1);
            SINK_PERIODIC: out_ready <= (cycle_count % 4 != 0);
            default: begin
                if (hold_left == 0) begin
                    out_ready <= ~out_ready;
                    hold_left = $urandom_range(1, 12);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    function automatic int active_steps(input logic [LEN_BITS-1:0] r);
        if (r == '0) return 1;
        if (r > MAX_STEPS) return MAX_STEPS;
        return r;
    endfunction

    // Sends one item; the sender works in bursts separated by random gaps.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (it.opcode != OP_UNUSED) items_sent++;
    endtask

    // Holds off the sender until every predicted match has come out and the pipe is empty.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Register write; the caller lowers valid after the last one of a group.
    task automatic write_reg(input t_cfg_index idx, input logic [TOL_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TOLERANCE:  tol_now = data;
            CFG_NORMAL_LEN: len_now[M_NORMAL] = active_steps(data[LEN_BITS-1:0]);
            CFG_REPEAT_LEN: len_now[M_REPEAT] = active_steps(data[LEN_BITS-1:0]);
            default: begin
            end
        endcase
    endtask

    task automatic send_write(input int m, input int idx, input logic [DURATION_BITS-1:0] e,
                              input logic lvl);
        t_in_item it;
        it.opcode      = (m == M_REPEAT) ? OP_WR_REPEAT : OP_WR_NORMAL;
        it.duration_us = e;
        it.line_level  = lvl;
        it.step_index  = STEP_BITS'(idx);
        pat_e[m][idx]  = e;
        pat_l[m][idx]  = lvl;
        send_item(it);
    endtask

    task automatic send_transition(input logic [DURATION_BITS-1:0] d, input logic lvl);
        t_in_item it;
        it.opcode      = OP_TRANSITION;
        it.duration_us = d;
        it.line_level  = lvl;
        it.step_index  = STEP_BITS'($urandom);
        send_item(it);
    endtask

    task automatic send_unused();
        t_in_item it;
        it.opcode      = OP_UNUSED;
        it.duration_us = DURATION_BITS'($urandom);
        it.line_level  = 1'($urandom);
        it.step_index  = STEP_BITS'($urandom);
        send_item(it);
    endtask

    // Expected step duration: mostly typical pulse widths, sometimes the extremes.
    function automatic logic [DURATION_BITS-1:0] pick_expected();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return DURATION_BITS'($urandom);
            default: return DURATION_BITS'($urandom_range(200, 12000));
        endcase
    endfunction

    // Measured duration for a step, aimed mostly inside tolerance and at its edges.
    function automatic logic [DURATION_BITS-1:0] pick_actual(input logic [DURATION_BITS-1:0] e,
                                                             input logic last);
        longint le;
        longint t;
        longint span;
        longint a;
        le = e;
        t  = tol_now;
        span = (t * le == 0) ? -1 : (t * le - 1) / 256;
        case ($urandom_range(0, 11))
            0:       a = le + span + 1;
            1:       a = le - span - 1;
            2:       a = le + span;
            3:       a = le - span;
            4:       a = last ? le + $urandom_range(1, 100000) : le;
            default: begin
                if (span < 0) a = last ? le + 1 : le;
                else a = le - span + $urandom_range(0, 32'(2 * span));
            end
        endcase
        if (a < 0) a = 0;
        if (a > longint'({DURATION_BITS{1'b1}})) a = longint'({DURATION_BITS{1'b1}});
        return DURATION_BITS'(a);
    endfunction

    // Sends the first steps of a header, with an occasional flipped level.
    task automatic send_frame(input int m, input int upto);
        logic lvl;
        for (int p = 0; p < upto; p++) begin
            lvl = pat_l[m][p];
            if ($urandom_range(0, 29) == 0) lvl = ~lvl;
            send_transition(pick_actual(pat_e[m][p], p == len_now[m] - 1), lvl);
        end
    endtask

    // One settings phase: registers, table load, then mixed traffic.
    task automatic run_phase(input logic [TOL_BITS-1:0] tol, input logic [TOL_BITS-1:0] nlen,
                             input logic [TOL_BITS-1:0] rlen, input int count);
        int start;
        int roll;
        int m;
        drain();
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_NORMAL_LEN, nlen);
        write_reg(CFG_REPEAT_LEN, rlen);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, TOL_BITS'($urandom));
        cfg_valid <= 1'b0;
        for (int k = 0; k < 2; k++) begin
            for (int p = 0; p < len_now[k]; p++) send_write(k, p, pick_expected(), 1'($urandom));
        end
        start = items_sent;
        while (items_sent - start < count) begin
            roll = $urandom_range(0, 99);
            m = $urandom_range(0, 1);
            if (roll < 40) send_frame(M_NORMAL, len_now[M_NORMAL]);
            else if (roll < 70) send_frame(M_REPEAT, len_now[M_REPEAT]);
            else if (roll < 80) send_frame(m, $urandom_range(1, len_now[m]));
            else if (roll < 90) send_transition(DURATION_BITS'($urandom), 1'($urandom));
            else if (roll < 95) send_write(m, $urandom_range(0, MAX_STEPS - 1), pick_expected(),
                                           1'($urandom));
            else send_unused();
        end
        // Leave the normal matcher part way through so the next settings may cut it short.
        send_frame(M_NORMAL, $urandom_range(1, len_now[M_NORMAL]));
        phases++;
    endtask

    // Directed checks under the reset settings: tolerance 51/256, one step per pattern.
    task automatic run_directed();
        send_write(M_NORMAL, 0, 24'd1000, 1'b1);
        send_write(M_REPEAT, 0, 24'hFFFFFF, 1'b0);
        send_transition(24'd1000, 1'b1);
        // Edges of the tolerance window around 1000.
        send_transition(24'd1199, 1'b1);
        send_transition(24'd801, 1'b1);
        send_transition(24'd800, 1'b1);
        // A longer last step matches and reports its excess.
        send_transition(24'd1200, 1'b1);
        send_transition(24'd1000, 1'b0);
        send_transition(24'hFFFFFF, 1'b0);
        send_transition(24'd0, 1'b1);
        send_unused();
        send_write(M_NORMAL, MAX_STEPS - 1, 24'hFFFFFF, 1'b1);
        // A zero expected duration is never inside tolerance, only exceeded.
        send_write(M_NORMAL, 0, 24'd0, 1'b1);
        send_transition(24'd0, 1'b1);
        send_transition(24'd1, 1'b1);
        // Both patterns match the same transition: the normal header wins.
        send_write(M_REPEAT, 0, 24'd0, 1'b1);
        send_transition(24'd5, 1'b1);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        // Register extremes first, including lengths that alias through the 5-bit field.
        run_phase(8'd255, 8'd16, 8'd1, 60);
        run_phase(8'd0, 8'd1, 8'd16, 40);
        run_phase(8'hE3, 8'd31, 8'd0, 50);
        run_phase(8'd51, 8'hE4, 8'h62, 50);
        while (items_sent < ITEM_TARGET) begin
            run_phase(($urandom_range(0, 4) == 0) ? TOL_BITS'($urandom)
                                                  : TOL_BITS'($urandom_range(20, 110)),
                      ($urandom_range(0, 7) == 0) ? TOL_BITS'($urandom)
                                                  : TOL_BITS'($urandom_range(1, 6)),
                      ($urandom_range(0, 7) == 0) ? TOL_BITS'($urandom)
                                                  : TOL_BITS'($urandom_range(1, 6)),
                      $urandom_range(60, 120));
        end
        drain();
        $display("Sent %0d items over %0d settings phases plus a directed opening;",
                 items_sent, phases);
        $display("%0d normal and %0d repeat headers were matched.", normal_hits, repeat_hits);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/phsm_pkg.sv
hw/rtl/phsm_matcher.sv
hw/rtl/pulse_sequence_header_matcher.sv
hw/rtl/phsm_checker.sv
bench/phsm_header_checker.sv
bench/tb_pulse_sequence_header_matcher.sv
